// ===== src/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// shared types, constants and the crc step for the servo frame deframer
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam logic [7:0]  START_BYTE   = 8'hA8;
   localparam logic [7:0]  TYPE_PLAIN   = 8'h01;
   localparam logic [7:0]  TYPE_FLAGGED = 8'h81;
   localparam logic [15:0] CRC_POLY     = 16'h1021;
   localparam logic [15:0] CRC_TOP      = 16'h8000;
   localparam logic        KIND_CHANNEL = 1'b0;
   localparam logic        KIND_SUMMARY = 1'b1;
   localparam int          DATA_BITS    = 88;

   // commands from the controller to the datapath
   typedef struct packed {
      logic crc_start;
      logic crc_update;
      logic set_type;
      logic set_count;
      logic data_store;
      logic crc_hi;
      logic crc_lo;
      logic idx_next;
      logic diff_capture;
      logic commit;
      logic emit_channel;
      logic emit_summary;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_start;
      logic is_type;
      logic count_big;
      logic count_zero;
      logic data_last;
      logic idx_end;
      logic ch_changed;
      logic differs;
      logic out_free;
   } status_type;

   // one byte of crc-16, msb first
   function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== src/sfd_ram.sv =====
// ----------------------------------------------------------------------------
// sfd_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sfd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfd_ctrl
// frame parser and end-of-frame sequencer state machine
// ----------------------------------------------------------------------------
module sfd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  sfd_pkg::status_type status,
   output sfd_pkg::cmd_type    cmd
);

   import sfd_pkg::*;

   typedef enum logic [3:0] {
      S_HUNT,
      S_TYPE,
      S_COUNT,
      S_DATA,
      S_CRCHI,
      S_CRCLO,
      S_CMP_RD,
      S_CMP_CHK,
      S_EMIT_RD,
      S_EMIT_CHK,
      S_SUMMARY
   } state_type;

   state_type state_ff, state_in;
   logic      ready;
   logic      accept;

   always_comb begin
      unique case (state_ff)
         S_HUNT, S_TYPE, S_COUNT, S_DATA, S_CRCHI, S_CRCLO: ready = 1'b1;
         default: ready = 1'b0;
      endcase
   end

   assign req_tready = ready;
   assign accept     = req_tvalid && ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_HUNT: begin
            if (accept && status.is_start) begin
               cmd.crc_start = 1'b1;
               state_in      = S_TYPE;
            end
         end
         S_TYPE: begin
            if (accept) begin
               if (status.is_type) begin
                  cmd.set_type   = 1'b1;
                  cmd.crc_update = 1'b1;
                  state_in       = S_COUNT;
               end else if (status.is_start) begin
                  cmd.crc_start = 1'b1;
               end else begin
                  state_in = S_HUNT;
               end
            end
         end
         S_COUNT: begin
            if (accept) begin
               if (status.count_big) begin
                  state_in = S_HUNT;
               end else begin
                  cmd.set_count  = 1'b1;
                  cmd.crc_update = 1'b1;
                  state_in       = status.count_zero ? S_CRCHI : S_DATA;
               end
            end
         end
         S_DATA: begin
            if (accept) begin
               cmd.crc_update = 1'b1;
               cmd.data_store = 1'b1;
               if (status.data_last) begin
                  state_in = S_CRCHI;
               end
            end
         end
         S_CRCHI: begin
            if (accept) begin
               cmd.crc_hi = 1'b1;
               state_in   = S_CRCLO;
            end
         end
         S_CRCLO: begin
            if (accept) begin
               cmd.crc_lo = 1'b1;
               state_in   = S_CMP_RD;
            end
         end
         S_CMP_RD: begin
            if (status.idx_end) begin
               if (status.differs) begin
                  cmd.commit = 1'b1;
                  state_in   = S_EMIT_RD;
               end else begin
                  state_in = S_SUMMARY;
               end
            end else begin
               state_in = S_CMP_CHK;
            end
         end
         S_CMP_CHK: begin
            cmd.diff_capture = 1'b1;
            cmd.idx_next     = 1'b1;
            state_in         = S_CMP_RD;
         end
         S_EMIT_RD: begin
            state_in = status.idx_end ? S_SUMMARY : S_EMIT_CHK;
         end
         S_EMIT_CHK: begin
            if (!status.ch_changed) begin
               cmd.idx_next = 1'b1;
               state_in     = S_EMIT_RD;
            end else if (status.out_free) begin
               cmd.emit_channel = 1'b1;
               cmd.idx_next     = 1'b1;
               state_in         = S_EMIT_RD;
            end
         end
         S_SUMMARY: begin
            if (status.out_free) begin
               cmd.emit_summary = 1'b1;
               state_in         = S_HUNT;
            end
         end
         default: state_in = S_HUNT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/sfd_datapath.sv =====
// ----------------------------------------------------------------------------
// sfd_datapath
// crc, frame registers, channel stores, counters and result register
// ----------------------------------------------------------------------------
module sfd_datapath #(
   parameter int MAX_CHANNELS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [7:0]                      req_tdata,
   input  sfd_pkg::cmd_type                cmd,
   output sfd_pkg::status_type             status,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sfd_pkg::DATA_BITS-1:0]   rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   import sfd_pkg::*;

   localparam int         CNT_W    = $clog2(MAX_CHANNELS + 1);
   localparam int         IDX_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int         POS_W    = CNT_W + 1;
   localparam logic [7:0] MAX_BYTE = 8'(MAX_CHANNELS);

   logic [15:0]      crc_ff;
   logic             type_ff;
   logic [CNT_W-1:0] total_ff;
   logic [POS_W-1:0] pos_ff;
   logic [7:0]       hold_ff;
   logic [15:0]      rx_crc_ff;
   logic             prev_type_ff;
   logic [CNT_W-1:0] prev_total_ff;
   logic [15:0]      prev_crc_ff;
   logic             has_prev_ff;
   logic             err_ff;
   logic             diff_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [31:0]      err_cnt_ff;
   logic [31:0]      frame_cnt_ff;

   logic             out_valid_ff;
   logic             out_kind_ff;
   logic [3:0]       out_index_ff;
   logic [15:0]      out_value_ff;
   logic             out_err_ff;
   logic [31:0]      out_err_total_ff;
   logic [31:0]      out_frame_total_ff;

   logic [15:0]      rx_full;
   logic             rx_err;
   logic             hdr_diff;
   logic [15:0]      new_rd;
   logic [15:0]      prev_rd;
   logic [15:0]      prev_masked;
   logic             ch_changed;
   logic             out_free;
   logic [7:0]       idx_byte;
   logic             new_wr_en;

   assign rx_full     = {rx_crc_ff[15:8], req_tdata};
   assign rx_err      = rx_full != crc_ff;
   assign hdr_diff    = !has_prev_ff || (type_ff != prev_type_ff) ||
                        (total_ff != prev_total_ff) || (rx_full != prev_crc_ff);
   // stored channels at or beyond the stored count read as zero
   assign prev_masked = (idx_ff < prev_total_ff) ? prev_rd : 16'h0000;
   assign ch_changed  = new_rd != prev_masked;
   assign out_free    = !out_valid_ff || rsp_tready;
   assign idx_byte    = 8'(idx_ff);
   assign new_wr_en   = cmd.data_store && pos_ff[0];

   assign status.is_start   = req_tdata == START_BYTE;
   assign status.is_type    = (req_tdata == TYPE_PLAIN) || (req_tdata == TYPE_FLAGGED);
   assign status.count_big  = req_tdata > MAX_BYTE;
   assign status.count_zero = req_tdata == 8'h00;
   assign status.data_last  = (pos_ff + POS_W'(1)) == {total_ff, 1'b0};
   assign status.idx_end    = idx_ff >= total_ff;
   assign status.ch_changed = ch_changed;
   assign status.differs    = diff_ff;
   assign status.out_free   = out_free;

   sfd_ram #(
      .WIDTH (16),
      .DEPTH (MAX_CHANNELS)
   ) u_new_ram (
      .clock   (clock),
      .wr_en   (new_wr_en),
      .wr_addr (pos_ff[IDX_W:1]),
      .wr_data ({hold_ff, req_tdata}),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (new_rd)
   );

   sfd_ram #(
      .WIDTH (16),
      .DEPTH (MAX_CHANNELS)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (cmd.idx_next && !cmd.diff_capture),
      .wr_addr (idx_ff[IDX_W-1:0]),
      .wr_data (new_rd),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (prev_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.crc_start) begin
         crc_ff <= crc_step(16'h0000, req_tdata);
      end else if (cmd.crc_update) begin
         crc_ff <= crc_step(crc_ff, req_tdata);
      end
      if (cmd.set_type) begin
         type_ff <= req_tdata[7];
      end
      if (cmd.data_store && !pos_ff[0]) begin
         hold_ff <= req_tdata;
      end
      if (cmd.crc_hi) begin
         rx_crc_ff <= {req_tdata, 8'h00};
      end else if (cmd.crc_lo) begin
         rx_crc_ff <= rx_full;
      end
      if (cmd.crc_lo) begin
         err_ff <= rx_err;
      end
      if (cmd.emit_summary && diff_ff) begin
         prev_type_ff <= type_ff;
         prev_crc_ff  <= rx_crc_ff;
      end
      if (cmd.emit_channel || cmd.emit_summary) begin
         out_kind_ff        <= cmd.emit_summary ? KIND_SUMMARY : KIND_CHANNEL;
         out_index_ff       <= cmd.emit_summary ? 4'h0 : idx_byte[3:0];
         out_value_ff       <= cmd.emit_summary ? 16'h0000 : new_rd;
         out_err_ff         <= err_ff;
         out_err_total_ff   <= err_cnt_ff;
         out_frame_total_ff <= frame_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         pos_ff        <= '0;
         idx_ff        <= '0;
         diff_ff       <= 1'b0;
         has_prev_ff   <= 1'b0;
         prev_total_ff <= '0;
         err_cnt_ff    <= '0;
         frame_cnt_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.set_count) begin
            total_ff <= req_tdata[CNT_W-1:0];
            pos_ff   <= '0;
         end else if (cmd.data_store) begin
            pos_ff <= pos_ff + POS_W'(1);
         end
         if (cmd.set_count || cmd.crc_lo || cmd.commit) begin
            idx_ff <= '0;
         end else if (cmd.idx_next) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         if (cmd.crc_lo) begin
            diff_ff <= hdr_diff;
            if (rx_err) begin
               err_cnt_ff <= err_cnt_ff + 32'd1;
            end
         end else if (cmd.diff_capture) begin
            diff_ff <= diff_ff | ch_changed;
         end
         if (cmd.commit) begin
            frame_cnt_ff <= frame_cnt_ff + 32'd1;
         end
         if (cmd.emit_summary && diff_ff) begin
            has_prev_ff   <= 1'b1;
            prev_total_ff <= total_ff;
         end
         if (cmd.emit_channel || cmd.emit_summary) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_kind_ff == KIND_SUMMARY;
   assign rsp_tdata  = {3'b000, out_frame_total_ff, out_err_total_ff, out_err_ff,
                        out_value_ff, out_index_ff};

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_channel || cmd.emit_summary) |-> (!out_valid_ff || rsp_tready))
      else $error("result register loaded while a result is still waiting");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= total_ff)
      else $error("channel index ran past the frame count");

   a_commit_once: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !cmd.commit && (frame_cnt_ff == $past(frame_cnt_ff) + 32'd1))
      else $error("frame counter did not advance once on commit");

endmodule

// ===== src/servo_frame_deframer_crc16_unit.sv =====
// ----------------------------------------------------------------------------
// servo_frame_deframer_crc16_unit
// serial servo frame deframer with crc-16 check and change reporting
// ----------------------------------------------------------------------------
// req channel carries one received byte per item. frames are 0xa8, a type
// byte (0x01 or 0x81), a count n, n big-endian 16-bit channels and a
// big-endian crc-16 (poly 0x1021, init 0) over all bytes before it.
// rsp channel carries one item per changed channel, in index order, then a
// summary item with tlast set, once per completed frame.
// frame bytes are taken whenever offered while a frame is parsed. after the
// last crc byte the input stalls while the end-of-frame sequencer runs: a
// compare pass over the two channel rams, then, when the frame differs from
// the stored one, an emit pass that also waits out any rsp stalls, then the
// summary. both passes step through the channels one at a time, through the
// single read port of each channel ram.
// results are registered in a one-deep output register; a stalled receiver
// holds the sequencer in place, nothing is lost.
// reset is synchronous: the parser returns to hunting for the start byte,
// counters and the stored frame clear; no clearing pass is needed since
// stored channels beyond the stored count read as zero.
// ----------------------------------------------------------------------------
module servo_frame_deframer_crc16_unit #(
   parameter int MAX_CHANNELS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // data_byte[7:0]
   input  logic [7:0]                    req_tdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // channel_index[3:0], channel_value[19:4], crc_error[20],
   // crc_error_total[52:21], frame_total[84:53], zero fill[87:85]
   output logic [sfd_pkg::DATA_BITS-1:0] rsp_tdata,
   // kind[0]
   output logic                          rsp_tuser,
   output logic                          rsp_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready
);

   import sfd_pkg::*;

   cmd_type    cmd;
   status_type status;

   sfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sfd_datapath #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== dv/servo_frame_deframer_crc16_unit_tb.sv =====
// ----------------------------------------------------------------------------
// servo_frame_deframer_crc16_unit_tb
// self-checking bench for the serial servo frame deframer
// ----------------------------------------------------------------------------
// byte items are fed on the req stream and predicted by a local frame parser
// that tracks the crc, the stored frame and both running counters. every rsp
// item is compared field by field with the oldest predicted result. directed
// frames cover noise, broken headers, oversize counts, zero count, a start
// byte inside the payload, a repeated frame and a full-size frame; random
// frames with sparse channel changes, crc errors and noise then run with and
// without sender gaps and receiver stalls. a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module servo_frame_deframer_crc16_unit_tb;
   import sfd_pkg::*;

   localparam int MAX_CH         = 16;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int END_PAUSE      = 100;

   typedef enum logic [2:0] {
      SEEK_START, SEEK_TYPE, SEEK_COUNT, TAKE_DATA, TAKE_CRC_HI, TAKE_CRC_LO
   } parse_phase_type;

   typedef struct {
      logic        kind;
      logic [3:0]  index;
      logic [15:0] value;
      logic        crc_bad;
      logic [31:0] crc_bad_total;
      logic [31:0] frames_total;
      logic        last;
   } servo_result_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic [7:0]           req_tdata  = 8'h00;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tlast;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;

   servo_frame_deframer_crc16_unit #(.MAX_CHANNELS(MAX_CH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),   // data_byte[7:0]
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),   // index, value, crc_error, error total, frame total
      .rsp_tuser  (rsp_tuser),   // kind
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #1 clock = ~clock;

   // predicted frame state
   parse_phase_type  ph;
   logic             cur_type;
   logic [4:0]       cur_count;
   logic [5:0]       byte_pos;
   logic [15:0]      crc_acc;
   logic [7:0]       hi_hold;
   logic [15:0]      rx_crc;
   logic [15:0]      cur_vals [MAX_CH];
   logic [15:0]      prev_vals [MAX_CH];
   logic             prev_type;
   logic [4:0]       prev_count;
   logic [15:0]      prev_crc;
   logic             have_prev;
   logic [31:0]      crc_bad_cnt;
   logic [31:0]      frame_cnt;
   logic             frame_bad;
   logic             frame_differs;
   servo_result_type expected_results [$];
   servo_result_type oldest;

   int               mismatch_count = 0;
   int               idle_cycles    = 0;
   int               byte_count     = 0;
   int               idle_pct       = 0;
   int               stall_pct      = 0;
   logic [15:0]      frame_vals [MAX_CH];
   logic [7:0]       last_frame [$];

   function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         if (r[15] ^ b[i]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic servo_result_type make_result(input logic kind, input logic [3:0] index,
                                                    input logic [15:0] value, input logic last);
      servo_result_type r;
      r.kind          = kind;
      r.index         = index;
      r.value         = value;
      r.crc_bad       = frame_bad;
      r.crc_bad_total = crc_bad_cnt;
      r.frames_total  = frame_cnt;
      r.last          = last;
      return r;
   endfunction

   // prediction on accepted bytes, then comparison of accepted results
   always @(posedge clock) begin
      if (reset) begin
         ph          = SEEK_START;
         cur_type    = 1'b0;
         cur_count   = '0;
         byte_pos    = '0;
         crc_acc     = '0;
         hi_hold     = '0;
         rx_crc      = '0;
         prev_type   = 1'b0;
         prev_count  = '0;
         prev_crc    = '0;
         have_prev   = 1'b0;
         crc_bad_cnt = '0;
         frame_cnt   = '0;
         for (int i = 0; i < MAX_CH; i++) begin
            cur_vals[i]  = '0;
            prev_vals[i] = '0;
         end
      end else begin
         if (req_tvalid && req_tready) begin
            case (ph)
               SEEK_START: begin
                  if (req_tdata == START_BYTE) begin
                     crc_acc = crc16_next(16'h0000, req_tdata);
                     ph      = SEEK_TYPE;
                  end
               end
               SEEK_TYPE: begin
                  if (req_tdata == TYPE_PLAIN || req_tdata == TYPE_FLAGGED) begin
                     cur_type = req_tdata[7];
                     crc_acc  = crc16_next(crc_acc, req_tdata);
                     ph       = SEEK_COUNT;
                  end else if (req_tdata == START_BYTE) begin
                     crc_acc = crc16_next(16'h0000, req_tdata);
                  end else begin
                     ph = SEEK_START;
                  end
               end
               SEEK_COUNT: begin
                  if (req_tdata > MAX_CH) begin
                     ph = SEEK_START;
                  end else begin
                     cur_count = req_tdata[4:0];
                     byte_pos  = '0;
                     crc_acc   = crc16_next(crc_acc, req_tdata);
                     ph        = (req_tdata == 8'h00) ? TAKE_CRC_HI : TAKE_DATA;
                  end
               end
               TAKE_DATA: begin
                  crc_acc = crc16_next(crc_acc, req_tdata);
                  if (!byte_pos[0]) begin
                     hi_hold = req_tdata;
                  end else begin
                     cur_vals[byte_pos[4:1]] = {hi_hold, req_tdata};
                  end
                  byte_pos = byte_pos + 6'd1;
                  if (byte_pos >= {cur_count, 1'b0}) begin
                     ph = TAKE_CRC_HI;
                  end
               end
               TAKE_CRC_HI: begin
                  rx_crc = {req_tdata, 8'h00};
                  ph     = TAKE_CRC_LO;
               end
               default: begin
                  rx_crc    = {rx_crc[15:8], req_tdata};
                  ph        = SEEK_START;
                  frame_bad = (rx_crc != crc_acc);
                  if (frame_bad) begin
                     crc_bad_cnt = crc_bad_cnt + 32'd1;
                  end
                  frame_differs = !have_prev || cur_type != prev_type ||
                                  cur_count != prev_count || rx_crc != prev_crc;
                  for (int i = 0; i < cur_count; i++) begin
                     if (cur_vals[i] != prev_vals[i]) begin
                        frame_differs = 1'b1;
                     end
                  end
                  if (frame_differs) begin
                     frame_cnt = frame_cnt + 32'd1;
                     for (int i = 0; i < cur_count; i++) begin
                        if (cur_vals[i] != prev_vals[i]) begin
                           expected_results.insert(expected_results.size(),
                              make_result(KIND_CHANNEL, 4'(i), cur_vals[i], 1'b0));
                        end
                     end
                     for (int i = 0; i < MAX_CH; i++) begin
                        prev_vals[i] = (i < cur_count) ? cur_vals[i] : 16'h0000;
                     end
                     prev_type  = cur_type;
                     prev_count = cur_count;
                     prev_crc   = rx_crc;
                     have_prev  = 1'b1;
                  end
                  expected_results.insert(expected_results.size(),
                     make_result(KIND_SUMMARY, 4'h0, 16'h0000, 1'b1));
               end
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result: kind %0d index %0d value %h last %0d",
                           rsp_tuser, rsp_tdata[3:0], rsp_tdata[19:4], rsp_tlast);
               end
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_tuser != oldest.kind || rsp_tdata[3:0] != oldest.index ||
                   rsp_tdata[19:4] != oldest.value || rsp_tdata[20] != oldest.crc_bad ||
                   rsp_tdata[52:21] != oldest.crc_bad_total ||
                   rsp_tdata[84:53] != oldest.frames_total ||
                   rsp_tdata[87:85] != 3'b000 || rsp_tlast != oldest.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display(
                        "exp kind %0d idx %0d val %h err %0d errs %0d frm %0d last %0d",
                        oldest.kind, oldest.index, oldest.value, oldest.crc_bad,
                        oldest.crc_bad_total, oldest.frames_total, oldest.last);
                     $display(
                        "act kind %0d idx %0d val %h err %0d errs %0d frm %0d last %0d fill %0d",
                        rsp_tuser, rsp_tdata[3:0], rsp_tdata[19:4], rsp_tdata[20],
                        rsp_tdata[52:21], rsp_tdata[84:53], rsp_tlast, rsp_tdata[87:85]);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("servo_frame_deframer_crc16_unit_tb: FAIL");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      byte_count++;
   endtask

   task automatic send_frame(input logic [7:0] type_b, input int n, input logic crc_good);
      logic [7:0]  fb [$];
      logic [15:0] c;
      fb = {};
      fb.insert(fb.size(), START_BYTE);
      fb.insert(fb.size(), type_b);
      fb.insert(fb.size(), 8'(n));
      for (int i = 0; i < n; i++) begin
         fb.insert(fb.size(), frame_vals[i][15:8]);
         fb.insert(fb.size(), frame_vals[i][7:0]);
      end
      c = 16'h0000;
      foreach (fb[i]) begin
         c = crc16_next(c, fb[i]);
      end
      if (!crc_good) begin
         c = c ^ 16'($urandom_range(1, 65535));
      end
      fb.insert(fb.size(), c[15:8]);
      fb.insert(fb.size(), c[7:0]);
      last_frame = fb;
      foreach (fb[i]) begin
         send_byte(fb[i]);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (END_PAUSE) @(posedge clock);
   endtask

   // noise, bad type, start byte as type, oversize count
   task automatic test_broken_headers();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(START_BYTE);
      send_byte(8'h02);
      send_byte(START_BYTE);
      send_byte(START_BYTE);
      send_byte(TYPE_PLAIN);
      send_byte(8'(MAX_CH + 1));
      drain();
   endtask

   task automatic test_zero_count_frame();
      send_frame(TYPE_PLAIN, 0, 1'b1);
      drain();
   endtask

   task automatic test_repeated_frame();
      foreach (last_frame[i]) begin
         send_byte(last_frame[i]);
      end
      drain();
   endtask

   task automatic test_start_byte_in_data();
      frame_vals[0] = 16'hFFFF;
      frame_vals[1] = {START_BYTE, 8'h00};
      send_frame(TYPE_FLAGGED, 2, 1'b0);
      drain();
   endtask

   task automatic test_max_count_frame();
      for (int i = 0; i < MAX_CH; i++) begin
         frame_vals[i] = 16'($urandom);
      end
      send_frame(TYPE_PLAIN, MAX_CH, 1'b1);
      drain();
   endtask

   task automatic test_random(input int idle_in, input int stall_in, input int n_bytes);
      int         start;
      int         pick;
      int         n;
      logic [7:0] b;
      idle_pct  = idle_in;
      stall_pct = stall_in;
      start     = byte_count;
      while (byte_count - start < n_bytes) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            case ($urandom_range(3))
               0: send_byte(8'($urandom));
               1: begin
                  do begin
                     b = 8'($urandom);
                  end while (b == TYPE_PLAIN || b == TYPE_FLAGGED);
                  send_byte(START_BYTE);
                  send_byte(b);
               end
               2: begin
                  send_byte(START_BYTE);
                  send_byte($urandom_range(1) ? TYPE_FLAGGED : TYPE_PLAIN);
                  send_byte(8'($urandom_range(MAX_CH + 1, 255)));
               end
               default: send_byte(START_BYTE);
            endcase
         end else if (pick < 20 && last_frame.size() != 0) begin
            foreach (last_frame[i]) begin
               send_byte(last_frame[i]);
            end
         end else begin
            n = ($urandom_range(7) == 0) ? $urandom_range(5, MAX_CH) : $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(9))
                  0, 1, 2, 3: ;
                  4: frame_vals[i] = 16'h0000;
                  5: frame_vals[i] = 16'hFFFF;
                  default: frame_vals[i] = 16'($urandom);
               endcase
            end
            send_frame($urandom_range(1) ? TYPE_FLAGGED : TYPE_PLAIN, n,
                       $urandom_range(99) < 85);
         end
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < MAX_CH; i++) begin
         frame_vals[i] = 16'h0000;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_broken_headers();
      test_zero_count_frame();
      test_repeated_frame();
      test_start_byte_in_data();
      test_max_count_frame();
      test_random(0, 0, 45);
      test_random(67, 0, 40);
      test_random(0, 67, 40);
      test_random(35, 35, 40);
      if (mismatch_count == 0) begin
         $display("servo_frame_deframer_crc16_unit_tb: PASS");
      end else begin
         $display("servo_frame_deframer_crc16_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
